FILE: design/kcft_pkg.sv
// Shared types and constants for the knob change and freeze tracker.
package kcft_pkg;

	// Number of knobs; each knob has a field port of its own
	localparam int KNOB_COUNT = 3;

	// Register widths
	localparam int TOL_W      = 8;
	localparam int FD_W       = 10;
	localparam int LIMIT_W    = 8;
	localparam int COUNT_W    = LIMIT_W + 1;
	localparam int CFG_DATA_W = 10;
	localparam int CFG_IDX_W  = 2;
	localparam int CMD_W      = 2;

	// Register reset values
	localparam logic [TOL_W-1:0]   TOL_RST   = TOL_W'(2);
	localparam logic [FD_W-1:0]    FD_RST    = FD_W'(8);
	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(16);

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE        = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FREEZE_DISTANCE  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE_LIMIT       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXTERNAL_RELEASE = 2'd3;

	// Commands
	typedef enum logic [CMD_W-1:0] {
		CMD_SCAN     = 2'd0,
		CMD_FREEZE   = 2'd1,
		CMD_UNFREEZE = 2'd2
	} cmd_t;

	// What one knob lane found in a scan
	typedef struct packed {
		logic far;    // jump beyond freeze distance
		logic moved;  // jump beyond tolerance
	} lane_flags_t;

	// Tracker state shared across knobs
	typedef struct packed {
		logic [KNOB_COUNT-1:0] changed;
		logic [KNOB_COUNT-1:0] frozen;
		logic [COUNT_W-1:0]    count;
	} track_state_t;

endpackage

FILE: design/kcft_lane.sv
// One knob lane: distance from the kept value and threshold compares.
module kcft_lane #(
	parameter int READING_BITS = 10
) (
	input  logic [READING_BITS-1:0]     reading,
	input  logic [READING_BITS-1:0]     kept,
	input  logic [kcft_pkg::TOL_W-1:0]  tolerance,
	input  logic [kcft_pkg::FD_W-1:0]   freeze_distance,
	output kcft_pkg::lane_flags_t       flags
);
	import kcft_pkg::*;

	localparam int CMP_W = (READING_BITS > FD_W) ? READING_BITS : FD_W;

	logic [READING_BITS-1:0] jump;

	// absolute difference
	assign jump = (reading > kept) ? (reading - kept) : (kept - reading);

	// compares at a common width
	assign flags.far   = CMP_W'(jump) > CMP_W'(freeze_distance);
	assign flags.moved = CMP_W'(jump) > CMP_W'(tolerance);

endmodule

FILE: design/kcft_merge.sv
// Merge stage: walks lane flags in knob order through the shared counter.
module kcft_merge (
	input  logic [kcft_pkg::CMD_W-1:0]                          cmd,
	input  logic [kcft_pkg::KNOB_COUNT-1:0]                     knob_mask,
	input  kcft_pkg::lane_flags_t [kcft_pkg::KNOB_COUNT-1:0]    flags,
	input  logic [kcft_pkg::LIMIT_W-1:0]                        idle_limit,
	input  logic                                                external_release,
	input  kcft_pkg::track_state_t                              cur,
	output kcft_pkg::track_state_t                              nxt
);
	import kcft_pkg::*;

	logic [KNOB_COUNT-1:0] release_hit;
	logic [COUNT_W-1:0]    limit_ext;

	// frozen knobs that jumped far enough to let go, unless external release is set
	always_comb begin
		for (int i = 0; i < KNOB_COUNT; i++) begin
			release_hit[i] = !external_release && cur.frozen[i] && flags[i].far;
		end
	end

	assign limit_ext = COUNT_W'(idle_limit);

	// counter chain in knob order, then command handling
	always_comb begin
		nxt = cur;
		unique case (cmd_t'(cmd))
			CMD_SCAN: begin
				nxt.frozen = cur.frozen & ~release_hit;
				for (int i = 0; i < KNOB_COUNT; i++) begin
					if (flags[i].moved) begin
						nxt.changed[i] = 1'b1;
						nxt.count      = '0;
					end else if (nxt.count > limit_ext) begin
						nxt.changed[i] = 1'b0;
					end else begin
						nxt.changed[i] = release_hit[i];
						nxt.count      = nxt.count + COUNT_W'(1);
					end
				end
			end
			CMD_FREEZE:   nxt.frozen = cur.frozen | knob_mask;
			CMD_UNFREEZE: nxt.frozen = cur.frozen & ~knob_mask;
			default: ;
		endcase
	end

endmodule

FILE: design/kcft_skid.sv
// Two-entry result buffer between the tracker state and the output port.
module kcft_skid #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] pop_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign pop_data  = mem_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

FILE: design/knob_change_freeze_tracker_core.sv
// Top level of the knob change and freeze tracker.
//
//  channel  | handshake            | words
//  ---------+----------------------+----------------------------------------------
//  in       | in_valid / in_stall  | cmd, knob_mask, reading_0..2
//  out      | out_valid / out_stall| changed_mask, frozen_mask, value_0..2,
//           |                      | previous_0..2
//  cfg      | cfg_wen              | cfg_index, cfg_data
//
// One input word per cycle while in_stall is low; every word yields one registered result word.
// Lanes and the counter chain settle within the accepting cycle; the state
// registers and the two-entry result buffer load at that edge.
// in_stall rises only when both buffer entries hold results not yet taken.
// Reset: all knobs frozen, values, changed bits and activity counter zero.
module knob_change_freeze_tracker_core #(
	parameter int READING_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [kcft_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [kcft_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [kcft_pkg::CMD_W-1:0]          cmd,
	input  logic [kcft_pkg::KNOB_COUNT-1:0]     knob_mask,
	input  logic [READING_BITS-1:0]             reading_0,
	input  logic [READING_BITS-1:0]             reading_1,
	input  logic [READING_BITS-1:0]             reading_2,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [kcft_pkg::KNOB_COUNT-1:0]     changed_mask,
	output logic [kcft_pkg::KNOB_COUNT-1:0]     frozen_mask,
	output logic [READING_BITS-1:0]             value_0,
	output logic [READING_BITS-1:0]             value_1,
	output logic [READING_BITS-1:0]             value_2,
	output logic [READING_BITS-1:0]             previous_0,
	output logic [READING_BITS-1:0]             previous_1,
	output logic [READING_BITS-1:0]             previous_2
);
	import kcft_pkg::*;

	localparam int VALS_W = KNOB_COUNT * READING_BITS;
	localparam int RES_W  = 2 * KNOB_COUNT + 2 * VALS_W;

	// configuration registers
	logic [TOL_W-1:0]   tolerance_q;
	logic [FD_W-1:0]    freeze_distance_q;
	logic [LIMIT_W-1:0] idle_limit_q;
	logic               external_release_q;

	// tracker state
	track_state_t            state_q;
	track_state_t            state_d;
	logic [VALS_W-1:0]       value_q;
	logic [VALS_W-1:0]       previous_q;
	logic [VALS_W-1:0]       value_d;
	logic [VALS_W-1:0]       previous_d;
	logic [VALS_W-1:0]       readings;

	lane_flags_t [KNOB_COUNT-1:0] flags;

	logic             accept;
	logic             is_scan;
	logic             buf_full;
	logic [RES_W-1:0] res_in;
	logic [RES_W-1:0] res_out;

	assign accept   = in_valid && !in_stall;
	assign in_stall = buf_full;
	assign is_scan  = cmd_t'(cmd) == CMD_SCAN;
	assign readings = {reading_2, reading_1, reading_0};

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tolerance_q        <= TOL_RST;
			freeze_distance_q  <= FD_RST;
			idle_limit_q       <= LIMIT_RST;
			external_release_q <= 1'b0;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				REG_TOLERANCE:        tolerance_q        <= cfg_data[TOL_W-1:0];
				REG_FREEZE_DISTANCE:  freeze_distance_q  <= cfg_data[FD_W-1:0];
				REG_IDLE_LIMIT:       idle_limit_q       <= cfg_data[LIMIT_W-1:0];
				REG_EXTERNAL_RELEASE: external_release_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// per-knob lanes
	for (genvar g = 0; g < KNOB_COUNT; g++) begin : g_lane
		kcft_lane #(
			.READING_BITS(READING_BITS)
		) u_lane (
			.reading         (readings[g*READING_BITS +: READING_BITS]),
			.kept            (value_q[g*READING_BITS +: READING_BITS]),
			.tolerance       (tolerance_q),
			.freeze_distance (freeze_distance_q),
			.flags           (flags[g])
		);
	end

	// merge lane flags through the shared counter
	kcft_merge u_merge (
		.cmd              (cmd),
		.knob_mask        (knob_mask),
		.flags            (flags),
		.idle_limit       (idle_limit_q),
		.external_release (external_release_q),
		.cur              (state_q),
		.nxt              (state_d)
	);

	// kept and previous values move only on a scan
	assign value_d    = is_scan ? readings : value_q;
	assign previous_d = is_scan ? value_q : previous_q;

	// state update on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.changed <= '0;
			state_q.frozen  <= '1;
			state_q.count   <= '0;
			value_q         <= '0;
			previous_q      <= '0;
		end else if (accept) begin
			state_q    <= state_d;
			value_q    <= value_d;
			previous_q <= previous_d;
		end
	end

	// result buffer
	assign res_in = {state_d.changed, state_d.frozen, value_d, previous_d};

	kcft_skid #(
		.WIDTH(RES_W)
	) u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (res_in),
		.full      (buf_full),
		.pop       (out_valid && !out_stall),
		.not_empty (out_valid),
		.pop_data  (res_out)
	);

	// unpack result word
	assign changed_mask = res_out[RES_W-1 -: KNOB_COUNT];
	assign frozen_mask  = res_out[RES_W-KNOB_COUNT-1 -: KNOB_COUNT];
	assign value_0      = res_out[VALS_W + 0*READING_BITS +: READING_BITS];
	assign value_1      = res_out[VALS_W + 1*READING_BITS +: READING_BITS];
	assign value_2      = res_out[VALS_W + 2*READING_BITS +: READING_BITS];
	assign previous_0   = res_out[0*READING_BITS +: READING_BITS];
	assign previous_1   = res_out[1*READING_BITS +: READING_BITS];
	assign previous_2   = res_out[2*READING_BITS +: READING_BITS];

endmodule

FILE: design/kcft_checker.sv
// Port-level checks for the knob tracker, bound to the top level.
module kcft_checker #(
	parameter int READING_BITS = 10
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic [kcft_pkg::KNOB_COUNT-1:0]     changed_mask,
	input logic [kcft_pkg::KNOB_COUNT-1:0]     frozen_mask,
	input logic [READING_BITS-1:0]             value_0,
	input logic [READING_BITS-1:0]             value_1,
	input logic [READING_BITS-1:0]             value_2,
	input logic [READING_BITS-1:0]             previous_0,
	input logic [READING_BITS-1:0]             previous_1,
	input logic [READING_BITS-1:0]             previous_2
);

	// input backs up only behind a pending result
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall high with no result pending");

	// an accepted word leaves a result pending at the output next cycle
	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted word produced no result");

	// no result appears without an accepted word
	a_no_invented_result: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall))
		else $error("result appeared without an accepted word");

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(changed_mask)
			&& $stable(frozen_mask) && $stable(value_0) && $stable(value_1)
			&& $stable(value_2) && $stable(previous_0) && $stable(previous_1)
			&& $stable(previous_2)))
		else $error("stalled result word changed");

endmodule

bind knob_change_freeze_tracker_core kcft_checker #(
	.READING_BITS(READING_BITS)
) u_kcft_checker (.*);
